// File: rtl/phol_pkg.sv
package phol_pkg;

   // Field widths of the request and response.
   localparam int POS_W    = 32;
   localparam int VEC_W    = 16;
   localparam int OUT_W    = 16;

   // Configuration register widths.
   localparam int PERIOD_W = 8;
   localparam int GAIN_W   = 16;
   localparam int LIM_W    = 17;
   localparam int STOP_W   = 15;
   localparam int CSR_W    = 17;
   localparam int CSR_IDX_W = 3;

   // Datapath widths.
   localparam int ERR_W    = POS_W + 1;
   localparam int MUL_A_W  = ERR_W;
   localparam int MUL_B_W  = VEC_W + 1;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int ACC_W    = PROD_W + 1;
   localparam int CLAMP_W  = LIM_W + 1;
   localparam int ROT_FRAC = 14;
   localparam int GAIN_FRAC = 8;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOOP_PERIOD     = 3'd0,
      CSR_GAIN_FORWARD    = 3'd1,
      CSR_GAIN_RIGHT      = 3'd2,
      CSR_ERR_LIM_FORWARD = 3'd3,
      CSR_ERR_LIM_RIGHT   = 3'd4,
      CSR_STOP_SPEED      = 3'd5,
      CSR_STOP_ACC        = 3'd6,
      CSR_LEVEL_LIMIT     = 3'd7
   } csr_index_type;

   // Datapath micro-operations issued by the controller.
   typedef enum logic [4:0] {
      OP_IDLE,
      OP_LOAD,
      OP_TICK,
      OP_SQ_VN,
      OP_SQ_VE,
      OP_SQ_VL,
      OP_SQ_AN,
      OP_SQ_AE,
      OP_SQ_AL,
      OP_DECIDE,
      OP_MUL_N_COS,
      OP_MUL_E_SIN,
      OP_MUL_E_COS,
      OP_MUL_N_SIN,
      OP_MUL_FWD_GAIN,
      OP_RGT_ERR,
      OP_MUL_RGT_GAIN,
      OP_RGT_OUT,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } phol_cmd_type;

   typedef struct packed {
      logic stick;
      logic due;
      logic target_zero;
   } phol_status_type;

endpackage

// File: rtl/phol_datapath.sv
module phol_datapath
   import phol_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  phol_cmd_type                cmd,
   output phol_status_type             status,
   input  logic                        req_stick_active,
   input  logic signed [POS_W-1:0]     req_pos_north,
   input  logic signed [POS_W-1:0]     req_pos_east,
   input  logic signed [VEC_W-1:0]     req_speed_north,
   input  logic signed [VEC_W-1:0]     req_speed_east,
   input  logic signed [VEC_W-1:0]     req_acc_north,
   input  logic signed [VEC_W-1:0]     req_acc_east,
   input  logic signed [VEC_W-1:0]     req_sin_heading,
   input  logic signed [VEC_W-1:0]     req_cos_heading,
   input  logic signed [VEC_W-1:0]     req_level_cos,
   output logic                        rsp_speed_set_valid,
   output logic signed [OUT_W-1:0]     rsp_speed_set_forward,
   output logic signed [OUT_W-1:0]     rsp_speed_set_right,
   output logic                        rsp_hovering,
   output logic                        rsp_target_captured,
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]            csr_wdata
);

   localparam logic signed [ACC_W:0] ROT_HALF =
      {{(ACC_W + 1 - ROT_FRAC){1'b0}}, 1'b1, {(ROT_FRAC - 1){1'b0}}};
   localparam logic signed [PROD_W:0] GAIN_HALF =
      {{(PROD_W + 1 - GAIN_FRAC){1'b0}}, 1'b1, {(GAIN_FRAC - 1){1'b0}}};
   localparam logic signed [PROD_W:0] SAT_HI =
      {{(PROD_W + 2 - OUT_W){1'b0}}, {(OUT_W - 1){1'b1}}};
   localparam logic signed [PROD_W:0] SAT_LO =
      {{(PROD_W + 2 - OUT_W){1'b1}}, {(OUT_W - 1){1'b0}}};

   function automatic logic signed [CLAMP_W-1:0] clamp_err(
      input logic signed [ACC_W:0] v,
      input logic [LIM_W-1:0]      lim
   );
      logic signed [ACC_W:0]   hi;
      logic signed [ACC_W:0]   lo;
      logic signed [CLAMP_W-1:0] res;
      hi = $signed({{(ACC_W + 1 - LIM_W){1'b0}}, lim});
      lo = -hi;
      if (v > hi) begin
         res = $signed({1'b0, lim});
      end else if (v < lo) begin
         res = -$signed({1'b0, lim});
      end else begin
         res = v[CLAMP_W-1:0];
      end
      return res;
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [PROD_W:0] v);
      logic signed [OUT_W-1:0] res;
      if (v > SAT_HI) begin
         res = SAT_HI[OUT_W-1:0];
      end else if (v < SAT_LO) begin
         res = SAT_LO[OUT_W-1:0];
      end else begin
         res = v[OUT_W-1:0];
      end
      return res;
   endfunction

   // Configuration registers.
   logic [PERIOD_W-1:0] loop_period_ff, loop_period_in;
   logic [GAIN_W-1:0]   gain_fwd_ff, gain_fwd_in;
   logic [GAIN_W-1:0]   gain_rgt_ff, gain_rgt_in;
   logic [LIM_W-1:0]    lim_fwd_ff, lim_fwd_in;
   logic [LIM_W-1:0]    lim_rgt_ff, lim_rgt_in;
   logic [STOP_W-1:0]   stop_speed_ff, stop_speed_in;
   logic [STOP_W-1:0]   stop_acc_ff, stop_acc_in;
   logic [STOP_W-1:0]   level_lim_ff, level_lim_in;

   // Loop state.
   logic [PERIOD_W-1:0]    tick_ff, tick_in;
   logic signed [POS_W-1:0] tgt_n_ff, tgt_n_in;
   logic signed [POS_W-1:0] tgt_e_ff, tgt_e_in;
   logic                   hover_ff, hover_in;

   // Latched request.
   logic                    stick_ff, stick_in;
   logic signed [POS_W-1:0] pos_n_ff, pos_n_in;
   logic signed [POS_W-1:0] pos_e_ff, pos_e_in;
   logic signed [VEC_W-1:0] vn_ff, vn_in;
   logic signed [VEC_W-1:0] ve_ff, ve_in;
   logic signed [VEC_W-1:0] an_ff, an_in;
   logic signed [VEC_W-1:0] ae_ff, ae_in;
   logic signed [VEC_W-1:0] sn_ff, sn_in;
   logic signed [VEC_W-1:0] cs_ff, cs_in;
   logic signed [VEC_W-1:0] lc_ff, lc_in;

   // Working registers.
   logic signed [ERR_W-1:0]   err_n_ff, err_n_in;
   logic signed [ERR_W-1:0]   err_e_ff, err_e_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [CLAMP_W-1:0] bf_ff, bf_in;
   logic signed [CLAMP_W-1:0] br_ff, br_in;
   logic                      stop_ok_ff, stop_ok_in;
   logic                      res_valid_ff, res_valid_in;
   logic signed [OUT_W-1:0]   res_fwd_ff, res_fwd_in;
   logic signed [OUT_W-1:0]   res_rgt_ff, res_rgt_in;
   logic                      res_cap_ff, res_cap_in;

   // Response register.
   logic                    out_valid_ff, out_valid_in;
   logic signed [OUT_W-1:0] out_fwd_ff, out_fwd_in;
   logic signed [OUT_W-1:0] out_rgt_ff, out_rgt_in;
   logic                    out_hover_ff, out_hover_in;
   logic                    out_cap_ff, out_cap_in;

   logic [PERIOD_W-1:0]       tick_next;
   logic                      due;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic                      mul_en;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [ACC_W:0]     acc_rnd;
   logic signed [ACC_W:0]     acc_cm;
   logic signed [PROD_W:0]    prod_rnd;
   logic signed [PROD_W:0]    prod_cm;
   logic                      level_ok;

   assign tick_next = tick_ff + PERIOD_W'(1);
   assign due       = (tick_next >= loop_period_ff);

   assign status.stick       = stick_ff;
   assign status.due         = due;
   assign status.target_zero = (tgt_n_ff == '0) && (tgt_e_ff == '0);

   assign prod_ext = {prod_ff[PROD_W-1], prod_ff};
   assign acc_rnd  = {acc_ff[ACC_W-1], acc_ff} + ROT_HALF;
   assign acc_cm   = acc_rnd >>> ROT_FRAC;
   assign prod_rnd = {prod_ff[PROD_W-1], prod_ff} + GAIN_HALF;
   assign prod_cm  = prod_rnd >>> GAIN_FRAC;
   assign level_ok = $signed({lc_ff[VEC_W-1], lc_ff}) >= $signed({2'b00, level_lim_ff});

   assign mul_p = mul_a * mul_b;

   // Shared multiplier operand selection.
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      case (cmd.op)
         OP_SQ_VN: begin
            mul_a = {{(MUL_A_W - VEC_W){vn_ff[VEC_W-1]}}, vn_ff};
            mul_b = {vn_ff[VEC_W-1], vn_ff};
         end
         OP_SQ_VE: begin
            mul_a = {{(MUL_A_W - VEC_W){ve_ff[VEC_W-1]}}, ve_ff};
            mul_b = {ve_ff[VEC_W-1], ve_ff};
         end
         OP_SQ_VL: begin
            mul_a = {{(MUL_A_W - STOP_W){1'b0}}, stop_speed_ff};
            mul_b = {2'b00, stop_speed_ff};
         end
         OP_SQ_AN: begin
            mul_a = {{(MUL_A_W - VEC_W){an_ff[VEC_W-1]}}, an_ff};
            mul_b = {an_ff[VEC_W-1], an_ff};
         end
         OP_SQ_AE: begin
            mul_a = {{(MUL_A_W - VEC_W){ae_ff[VEC_W-1]}}, ae_ff};
            mul_b = {ae_ff[VEC_W-1], ae_ff};
         end
         OP_SQ_AL: begin
            mul_a = {{(MUL_A_W - STOP_W){1'b0}}, stop_acc_ff};
            mul_b = {2'b00, stop_acc_ff};
         end
         OP_MUL_N_COS: begin
            mul_a = err_n_ff;
            mul_b = {cs_ff[VEC_W-1], cs_ff};
         end
         OP_MUL_E_SIN: begin
            mul_a = err_e_ff;
            mul_b = {sn_ff[VEC_W-1], sn_ff};
         end
         OP_MUL_E_COS: begin
            mul_a = err_e_ff;
            mul_b = {cs_ff[VEC_W-1], cs_ff};
         end
         OP_MUL_N_SIN: begin
            mul_a = err_n_ff;
            mul_b = {sn_ff[VEC_W-1], sn_ff};
         end
         OP_MUL_FWD_GAIN: begin
            mul_a = {{(MUL_A_W - CLAMP_W){bf_ff[CLAMP_W-1]}}, bf_ff};
            mul_b = {1'b0, gain_fwd_ff};
         end
         OP_MUL_RGT_GAIN: begin
            mul_a = {{(MUL_A_W - CLAMP_W){br_ff[CLAMP_W-1]}}, br_ff};
            mul_b = {1'b0, gain_rgt_ff};
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   // Register write decode.
   always_comb begin
      loop_period_in = loop_period_ff;
      gain_fwd_in    = gain_fwd_ff;
      gain_rgt_in    = gain_rgt_ff;
      lim_fwd_in     = lim_fwd_ff;
      lim_rgt_in     = lim_rgt_ff;
      stop_speed_in  = stop_speed_ff;
      stop_acc_in    = stop_acc_ff;
      level_lim_in   = level_lim_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_LOOP_PERIOD:     loop_period_in = csr_wdata[PERIOD_W-1:0];
            CSR_GAIN_FORWARD:    gain_fwd_in    = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_RIGHT:      gain_rgt_in    = csr_wdata[GAIN_W-1:0];
            CSR_ERR_LIM_FORWARD: lim_fwd_in     = csr_wdata[LIM_W-1:0];
            CSR_ERR_LIM_RIGHT:   lim_rgt_in     = csr_wdata[LIM_W-1:0];
            CSR_STOP_SPEED:      stop_speed_in  = csr_wdata[STOP_W-1:0];
            CSR_STOP_ACC:        stop_acc_in    = csr_wdata[STOP_W-1:0];
            CSR_LEVEL_LIMIT:     level_lim_in   = csr_wdata[STOP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Micro-operation execution.
   always_comb begin
      tick_in      = tick_ff;
      tgt_n_in     = tgt_n_ff;
      tgt_e_in     = tgt_e_ff;
      hover_in     = hover_ff;
      stick_in     = stick_ff;
      pos_n_in     = pos_n_ff;
      pos_e_in     = pos_e_ff;
      vn_in        = vn_ff;
      ve_in        = ve_ff;
      an_in        = an_ff;
      ae_in        = ae_ff;
      sn_in        = sn_ff;
      cs_in        = cs_ff;
      lc_in        = lc_ff;
      err_n_in     = err_n_ff;
      err_e_in     = err_e_ff;
      prod_in      = mul_en ? mul_p : prod_ff;
      acc_in       = acc_ff;
      bf_in        = bf_ff;
      br_in        = br_ff;
      stop_ok_in   = stop_ok_ff;
      res_valid_in = res_valid_ff;
      res_fwd_in   = res_fwd_ff;
      res_rgt_in   = res_rgt_ff;
      res_cap_in   = res_cap_ff;
      out_valid_in = out_valid_ff;
      out_fwd_in   = out_fwd_ff;
      out_rgt_in   = out_rgt_ff;
      out_hover_in = out_hover_ff;
      out_cap_in   = out_cap_ff;
      case (cmd.op)
         OP_LOAD: begin
            stick_in = req_stick_active;
            pos_n_in = req_pos_north;
            pos_e_in = req_pos_east;
            vn_in    = req_speed_north;
            ve_in    = req_speed_east;
            an_in    = req_acc_north;
            ae_in    = req_acc_east;
            sn_in    = req_sin_heading;
            cs_in    = req_cos_heading;
            lc_in    = req_level_cos;
         end
         OP_TICK: begin
            res_valid_in = 1'b0;
            res_fwd_in   = '0;
            res_rgt_in   = '0;
            res_cap_in   = 1'b0;
            err_n_in     = {tgt_n_ff[POS_W-1], tgt_n_ff} - {pos_n_ff[POS_W-1], pos_n_ff};
            err_e_in     = {tgt_e_ff[POS_W-1], tgt_e_ff} - {pos_e_ff[POS_W-1], pos_e_ff};
            if (stick_ff) begin
               tgt_n_in = '0;
               tgt_e_in = '0;
            end else begin
               tick_in = due ? '0 : tick_next;
            end
         end
         OP_SQ_VE, OP_SQ_AE, OP_MUL_E_SIN: begin
            acc_in = prod_ext;
         end
         OP_SQ_VL, OP_SQ_AL, OP_MUL_FWD_GAIN: begin
            acc_in = acc_ff + prod_ext;
         end
         OP_SQ_AN: begin
            stop_ok_in = (acc_ff <= prod_ext);
         end
         OP_DECIDE: begin
            if (stop_ok_ff && (acc_ff <= prod_ext) && level_ok) begin
               tgt_n_in   = pos_n_ff;
               tgt_e_in   = pos_e_ff;
               hover_in   = 1'b1;
               res_cap_in = 1'b1;
            end else begin
               hover_in     = 1'b0;
               res_valid_in = 1'b1;
            end
         end
         OP_MUL_E_COS: begin
            acc_in = acc_ff - prod_ext;
         end
         OP_MUL_N_SIN: begin
            bf_in  = clamp_err(acc_cm, lim_fwd_ff);
            acc_in = prod_ext;
         end
         OP_RGT_ERR: begin
            br_in      = clamp_err(acc_cm, lim_rgt_ff);
            res_fwd_in = sat_out(prod_cm);
         end
         OP_RGT_OUT: begin
            res_rgt_in   = sat_out(prod_cm);
            res_valid_in = 1'b1;
         end
         OP_EMIT: begin
            out_valid_in = res_valid_ff;
            out_fwd_in   = res_fwd_ff;
            out_rgt_in   = res_rgt_ff;
            out_hover_in = hover_ff;
            out_cap_in   = res_cap_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_period_ff <= PERIOD_W'(4);
         gain_fwd_ff    <= GAIN_W'(256);
         gain_rgt_ff    <= GAIN_W'(256);
         lim_fwd_ff     <= LIM_W'(1000);
         lim_rgt_ff     <= LIM_W'(1000);
         stop_speed_ff  <= STOP_W'(20);
         stop_acc_ff    <= STOP_W'(40);
         level_lim_ff   <= STOP_W'(15892);
         tick_ff        <= '0;
         tgt_n_ff       <= '0;
         tgt_e_ff       <= '0;
         hover_ff       <= 1'b0;
      end else begin
         loop_period_ff <= loop_period_in;
         gain_fwd_ff    <= gain_fwd_in;
         gain_rgt_ff    <= gain_rgt_in;
         lim_fwd_ff     <= lim_fwd_in;
         lim_rgt_ff     <= lim_rgt_in;
         stop_speed_ff  <= stop_speed_in;
         stop_acc_ff    <= stop_acc_in;
         level_lim_ff   <= level_lim_in;
         tick_ff        <= tick_in;
         tgt_n_ff       <= tgt_n_in;
         tgt_e_ff       <= tgt_e_in;
         hover_ff       <= hover_in;
      end
   end

   always_ff @(posedge clock) begin
      stick_ff     <= stick_in;
      pos_n_ff     <= pos_n_in;
      pos_e_ff     <= pos_e_in;
      vn_ff        <= vn_in;
      ve_ff        <= ve_in;
      an_ff        <= an_in;
      ae_ff        <= ae_in;
      sn_ff        <= sn_in;
      cs_ff        <= cs_in;
      lc_ff        <= lc_in;
      err_n_ff     <= err_n_in;
      err_e_ff     <= err_e_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      bf_ff        <= bf_in;
      br_ff        <= br_in;
      stop_ok_ff   <= stop_ok_in;
      res_valid_ff <= res_valid_in;
      res_fwd_ff   <= res_fwd_in;
      res_rgt_ff   <= res_rgt_in;
      res_cap_ff   <= res_cap_in;
      out_valid_ff <= out_valid_in;
      out_fwd_ff   <= out_fwd_in;
      out_rgt_ff   <= out_rgt_in;
      out_hover_ff <= out_hover_in;
      out_cap_ff   <= out_cap_in;
   end

   assign rsp_speed_set_valid   = out_valid_ff;
   assign rsp_speed_set_forward = out_fwd_ff;
   assign rsp_speed_set_right   = out_rgt_ff;
   assign rsp_hovering          = out_hover_ff;
   assign rsp_target_captured   = out_cap_ff;

endmodule

// File: rtl/phol_ctrl.sv
module phol_ctrl
   import phol_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  phol_status_type status,
   output phol_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_TICK  = 5'b00010,
      ST_STOP  = 5'b00100,
      ST_TRACK = 5'b01000,
      ST_EMIT  = 5'b10000
   } ctrl_state_type;

   localparam logic [2:0] STOP_LAST  = 3'd6;
   localparam logic [2:0] TRACK_LAST = 3'd7;

   function automatic op_type stop_op(input logic [2:0] step);
      op_type op;
      case (step)
         3'd0:    op = OP_SQ_VN;
         3'd1:    op = OP_SQ_VE;
         3'd2:    op = OP_SQ_VL;
         3'd3:    op = OP_SQ_AN;
         3'd4:    op = OP_SQ_AE;
         3'd5:    op = OP_SQ_AL;
         3'd6:    op = OP_DECIDE;
         default: op = OP_IDLE;
      endcase
      return op;
   endfunction

   function automatic op_type track_op(input logic [2:0] step);
      op_type op;
      case (step)
         3'd0:    op = OP_MUL_N_COS;
         3'd1:    op = OP_MUL_E_SIN;
         3'd2:    op = OP_MUL_E_COS;
         3'd3:    op = OP_MUL_N_SIN;
         3'd4:    op = OP_MUL_FWD_GAIN;
         3'd5:    op = OP_RGT_ERR;
         3'd6:    op = OP_MUL_RGT_GAIN;
         3'd7:    op = OP_RGT_OUT;
         default: op = OP_IDLE;
      endcase
      return op;
   endfunction

   ctrl_state_type state_ff, state_in;
   logic [2:0]     step_ff, step_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = OP_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_TICK;
            end
         end
         ST_TICK: begin
            cmd.op  = OP_TICK;
            step_in = '0;
            if (status.stick || !status.due) begin
               state_in = ST_EMIT;
            end else if (status.target_zero) begin
               state_in = ST_STOP;
            end else begin
               state_in = ST_TRACK;
            end
         end
         ST_STOP: begin
            cmd.op = stop_op(step_ff);
            if (step_ff == STOP_LAST) begin
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_TRACK: begin
            cmd.op = track_op(step_ff);
            if (step_ff == TRACK_LAST) begin
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_to_tick: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_TICK))
      else $error("accepted request did not move to the tick step");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response register overwritten while held");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("response not presented after emit");

   a_stop_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STOP) |-> (step_ff <= STOP_LAST))
      else $error("stop test step counter out of range");
`endif

endmodule

// File: rtl/position_hold_outer_loop.sv
// Channel   Handshake            Direction  Contents
// req_      req_valid/req_stall  in         one control tick: stick, position, speed,
//                                           acceleration, heading sine/cosine, level cosine
// rsp_      rsp_valid/rsp_stall  out        speed setpoints, setpoint valid, hover, capture
// csr_      csr_write            in         register index and write data, no read-back
//
// A request skips the multiply steps when the stick is deflected or the loop is not
// due, runs a stop test when no target is held and tracks the target otherwise; all
// products come from the single shared 33x17 multiplier, one product per cycle.
// A new request is taken while the previous response still waits on rsp_stall;
// only the final emit step waits for the response register to free up.
// Reset is synchronous and active high and restores the configuration registers
// to their defaults and clears the tick counter, the hold target and the hover flag.
module position_hold_outer_loop
   import phol_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_stick_active,
   input  logic signed [POS_W-1:0] req_pos_north,
   input  logic signed [POS_W-1:0] req_pos_east,
   input  logic signed [VEC_W-1:0] req_speed_north,
   input  logic signed [VEC_W-1:0] req_speed_east,
   input  logic signed [VEC_W-1:0] req_acc_north,
   input  logic signed [VEC_W-1:0] req_acc_east,
   input  logic signed [VEC_W-1:0] req_sin_heading,
   input  logic signed [VEC_W-1:0] req_cos_heading,
   input  logic signed [VEC_W-1:0] req_level_cos,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_speed_set_valid,
   output logic signed [OUT_W-1:0] rsp_speed_set_forward,
   output logic signed [OUT_W-1:0] rsp_speed_set_right,
   output logic                    rsp_hovering,
   output logic                    rsp_target_captured,

   input  logic                    csr_write,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_wdata
);

   // The controller walks each request through datapath operations: latch the
   // request, advance the tick divider or, with the stick deflected, clear the
   // hold target; if due, either the stop test (squared speed and acceleration
   // magnitudes against squared limits) or the tracking sequence (body-frame
   // rotation, clamp, gain); finally copy the result into the response register.
   phol_cmd_type    cmd;
   phol_status_type status;

   phol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the registers, the hold target, the hover flag and
   // the single shared multiplier with its accumulator.
   phol_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_stick_active      (req_stick_active),
      .req_pos_north         (req_pos_north),
      .req_pos_east          (req_pos_east),
      .req_speed_north       (req_speed_north),
      .req_speed_east        (req_speed_east),
      .req_acc_north         (req_acc_north),
      .req_acc_east          (req_acc_east),
      .req_sin_heading       (req_sin_heading),
      .req_cos_heading       (req_cos_heading),
      .req_level_cos         (req_level_cos),
      .rsp_speed_set_valid   (rsp_speed_set_valid),
      .rsp_speed_set_forward (rsp_speed_set_forward),
      .rsp_speed_set_right   (rsp_speed_set_right),
      .rsp_hovering          (rsp_hovering),
      .rsp_target_captured   (rsp_target_captured),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

endmodule
